/* sv/hhff_pkg.sv */
// Package for the header field framer: payload structs, event and cause codes,
// and byte classes. Used by every module of the block; depends on nothing.
package hhff_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } hhff_in_t;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [3:0]  cause;
        logic [15:0] name_offset;
        logic [15:0] name_length;
        logic [15:0] value_offset;
        logic [15:0] value_length;
        logic        last_result;
    } hhff_out_t;

    localparam logic [1:0] EV_KEPT     = 2'd0;
    localparam logic [1:0] EV_IGNORED  = 2'd1;
    localparam logic [1:0] EV_ACCEPTED = 2'd2;
    localparam logic [1:0] EV_REJECTED = 2'd3;

    localparam logic [3:0] CS_NONE      = 4'd0;
    localparam logic [3:0] CS_NUL       = 4'd1;
    localparam logic [3:0] CS_NO_LF     = 4'd2;
    localparam logic [3:0] CS_STRAY_CR  = 4'd3;
    localparam logic [3:0] CS_BLANK_CON = 4'd4;
    localparam logic [3:0] CS_EARLY_BLK = 4'd5;
    localparam logic [3:0] CS_NO_NAME   = 4'd6;
    localparam logic [3:0] CS_NAME_LONG = 4'd7;
    localparam logic [3:0] CS_VAL_LONG  = 4'd8;
    localparam logic [3:0] CS_NAME_WS   = 4'd9;

    localparam logic [1:0] CFG_RELAXED  = 2'd0;
    localparam logic [1:0] CFG_MAX_NAME = 2'd1;
    localparam logic [1:0] CFG_MAX_VAL  = 2'd2;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [15:0] LEN_RESET = 16'd65534;

    typedef enum logic [1:0] {
        PH_START    = 2'd0,
        PH_LINE     = 2'd1,
        PH_AFTER_LF = 2'd2,
        PH_FAILED   = 2'd3
    } hhff_phase_t;

    // Snapshot of a finished field, handed from the scanner to the emitter.
    typedef struct packed {
        logic        colon_seen;
        logic [15:0] start;
        logic [15:0] colon_off;
        logic        name_ns_seen;
        logic [15:0] name_last_ns;
        logic        name_sp_seen;
        logic        val_ns_seen;
        logic [15:0] val_first_ns;
        logic [15:0] val_last_ns;
        logic [15:0] end_off;
    } hhff_field_t;

    function automatic logic is_trim_space(input logic [7:0] b);
        return (b == CH_SP) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_name_space(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
    endfunction

endpackage

/* sv/hhff_emit.sv */
// Field result builder: turns a finished field snapshot into a result item.
// Depends on hhff_pkg.
module hhff_emit
    import hhff_pkg::*;
(
    input  hhff_field_t fld,
    input  logic        relaxed_mode,
    input  logic [15:0] max_name_length,
    input  logic [15:0] max_value_length,
    output hhff_out_t   res
);
    logic [15:0] raw_nl;
    logic [15:0] trim_nl;
    logic [15:0] nl;
    logic [15:0] vs;
    logic [15:0] vl;

    always_comb
    begin
        raw_nl  = fld.colon_off - fld.start;
        trim_nl = fld.name_ns_seen ? (fld.name_last_ns - fld.start + 16'd1) : 16'd0;
        nl      = relaxed_mode ? trim_nl : raw_nl;
        vs      = fld.val_ns_seen ? fld.val_first_ns : fld.end_off;
        vl      = fld.val_ns_seen ? (fld.val_last_ns - fld.val_first_ns + 16'd1) : 16'd0;
        res     = '0;
        res.name_offset = fld.start;
        priority if (!fld.colon_seen || fld.colon_off == fld.start)
        begin
            res.event_res = EV_IGNORED;
            res.cause     = CS_NO_NAME;
        end
        else if (raw_nl > max_name_length)
        begin
            res.event_res   = EV_IGNORED;
            res.cause       = CS_NAME_LONG;
            res.name_length = raw_nl;
        end
        else if (relaxed_mode && trim_nl == 16'd0)
        begin
            res.event_res = EV_IGNORED;
            res.cause     = CS_NO_NAME;
        end
        else
        begin
            res.name_length  = nl;
            res.value_offset = vs;
            res.value_length = vl;
            if (vl > max_value_length)
            begin
                res.event_res = EV_IGNORED;
                res.cause     = CS_VAL_LONG;
            end
            else if (!relaxed_mode && fld.name_sp_seen)
            begin
                res.event_res = EV_IGNORED;
                res.cause     = CS_NAME_WS;
            end
            else
            begin
                res.event_res = EV_KEPT;
                res.cause     = CS_NONE;
            end
        end
    end
endmodule

/* sv/hhff_scan.sv */
// Byte scanner: holds the per-field parse state and computes, for one byte,
// the next state and up to two result items. Depends on hhff_pkg, hhff_emit.
module hhff_scan
    import hhff_pkg::*;
#(
    parameter int POS_MAX = 65535
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  hhff_in_t    item,
    input  logic        relaxed_mode,
    input  logic [15:0] max_name_length,
    input  logic [15:0] max_value_length,
    output logic [1:0]  res_count,
    output hhff_out_t   res0,
    output hhff_out_t   res1
);
    hhff_phase_t phase_reg, phase_next;
    hhff_field_t fld_reg, fld_next;
    logic        empty_reg, empty_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] line_len_reg, line_len_next;
    logic [1:0]  crs_reg, crs_next;
    logic        stray_reg, stray_next;
    logic        cont_reg, cont_next;
    logic [3:0]  rcause_reg, rcause_next;

    hhff_field_t emit_fld;
    hhff_out_t   emit_res;
    hhff_out_t   term_res;

    hhff_emit u_emit (
        .fld              (emit_fld),
        .relaxed_mode     (relaxed_mode),
        .max_name_length  (max_name_length),
        .max_value_length (max_value_length),
        .res              (emit_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            fld_reg      <= '0;
            empty_reg    <= 1'b0;
            pos_reg      <= '0;
            line_len_reg <= '0;
            crs_reg      <= '0;
            stray_reg    <= 1'b0;
            cont_reg     <= 1'b0;
            rcause_reg   <= CS_NONE;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            fld_reg      <= fld_next;
            empty_reg    <= empty_next;
            pos_reg      <= pos_next;
            line_len_reg <= line_len_next;
            crs_reg      <= crs_next;
            stray_reg    <= stray_next;
            cont_reg     <= cont_next;
            rcause_reg   <= rcause_next;
        end
    end

    always_comb
    begin
        logic [7:0]  b;
        logic        do_line;
        logic        fail;
        logic        emit_mid;
        logic        stray;
        logic [1:0]  strip;
        logic [15:0] content;
        hhff_field_t cur;

        b            = item.byte_value;
        phase_next   = phase_reg;
        fld_next     = fld_reg;
        empty_next   = empty_reg;
        line_len_next = line_len_reg;
        crs_next     = crs_reg;
        stray_next   = stray_reg;
        cont_next    = cont_reg;
        rcause_next  = rcause_reg;
        do_line      = 1'b0;
        fail         = 1'b0;
        emit_mid     = 1'b0;
        strip        = 2'd0;
        content      = '0;
        stray        = 1'b0;
        emit_fld     = fld_reg;
        cur          = fld_reg;

        if (b == 8'h00)
        begin
            rcause_next = CS_NUL;
            phase_next  = PH_FAILED;
        end
        else if (phase_reg != PH_FAILED)
        begin
            do_line = 1'b1;
            unique case (phase_reg)
                PH_START:
                begin
                    cur = '0;
                    cur.start = pos_reg;
                    cont_next = 1'b0;
                    line_len_next = '0;
                    crs_next = '0;
                    stray_next = 1'b0;
                end
                PH_AFTER_LF:
                begin
                    if (b == CH_SP || b == CH_TAB)
                    begin
                        cont_next = 1'b1;
                        line_len_next = '0;
                        crs_next = '0;
                        stray_next = 1'b0;
                    end
                    else if (empty_reg)
                    begin
                        rcause_next = CS_EARLY_BLK;
                        phase_next  = PH_FAILED;
                        do_line     = 1'b0;
                    end
                    else
                    begin
                        emit_mid = 1'b1;
                        cur = '0;
                        cur.start = pos_reg;
                        cont_next = 1'b0;
                        line_len_next = '0;
                        crs_next = '0;
                        stray_next = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase

            if (do_line)
            begin
                phase_next = PH_LINE;
                // Field tracking for this byte.
                if (!cur.colon_seen)
                begin
                    if (b == CH_COLON)
                    begin
                        cur.colon_seen = 1'b1;
                        cur.colon_off  = pos_reg;
                    end
                    else
                    begin
                        if (!is_trim_space(b))
                        begin
                            cur.name_last_ns = pos_reg;
                            cur.name_ns_seen = 1'b1;
                        end
                        if (is_name_space(b))
                            cur.name_sp_seen = 1'b1;
                    end
                end
                else if (!is_trim_space(b))
                begin
                    if (!cur.val_ns_seen)
                    begin
                        cur.val_first_ns = pos_reg;
                        cur.val_ns_seen  = 1'b1;
                    end
                    cur.val_last_ns = pos_reg;
                end

                if (b == CH_LF)
                begin
                    if (crs_next >= 2'd1)
                    begin
                        strip = 2'd1;
                        if (relaxed_mode && crs_next >= 2'd2 && line_len_next >= 16'd3)
                            strip = 2'd2;
                    end
                    stray   = stray_next || (crs_next > strip);
                    content = line_len_next - {14'd0, strip};
                    if (stray && !relaxed_mode)
                    begin
                        rcause_next = CS_STRAY_CR;
                        phase_next  = PH_FAILED;
                    end
                    else if (cont_next && content == 16'd1)
                    begin
                        rcause_next = CS_BLANK_CON;
                        phase_next  = PH_FAILED;
                    end
                    else
                    begin
                        cur.end_off = pos_reg - {14'd0, strip};
                        empty_next  = !cont_next && content == 16'd0;
                        phase_next  = PH_AFTER_LF;
                    end
                end
                else
                begin
                    if (line_len_next != 16'hFFFF)
                        line_len_next = line_len_next + 16'd1;
                    if (b == CH_CR)
                    begin
                        if (crs_next != 2'd3)
                            crs_next = crs_next + 2'd1;
                    end
                    else
                    begin
                        if (crs_next != 2'd0)
                            stray_next = 1'b1;
                        crs_next = '0;
                    end
                end
            end
            fld_next = cur;
        end

        // Terminating result on the last byte.
        fail = (phase_next != PH_AFTER_LF);
        term_res = '0;
        term_res.last_result = 1'b1;
        if (fail)
        begin
            term_res.event_res = EV_REJECTED;
            term_res.cause     = (phase_next == PH_FAILED) ? rcause_next : CS_NO_LF;
        end
        else
            term_res.event_res = EV_ACCEPTED;

        if (!emit_mid)
            emit_fld = fld_next;

        res0 = emit_res;
        res1 = term_res;
        res_count = 2'd0;
        if (emit_mid)
        begin
            res_count = 2'd1;
            res0.last_result = !item.last_byte;
        end
        if (item.last_byte)
        begin
            if (emit_mid)
            begin
                // Field from the previous line plus the terminating result.
                res_count = 2'd2;
            end
            else if (!fail && !empty_next)
            begin
                res_count = 2'd2;
                res0.last_result = 1'b0;
            end
            else
            begin
                res_count = 2'd1;
                res0 = term_res;
            end
        end

        if (item.last_byte)
        begin
            pos_next   = '0;
            phase_next = PH_START;
            rcause_next = CS_NONE;
            empty_next = 1'b0;
            fld_next   = '0;
        end
        else if (32'(pos_reg) < POS_MAX)
            pos_next = pos_reg + 16'd1;
        else
            pos_next = pos_reg;
    end
endmodule

/* sv/hhff_outq.sv */
// Output queue: holds up to two result items per byte and drains them one
// transfer at a time. Depends on hhff_pkg.
module hhff_outq
    import hhff_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic [1:0] push_count,
    input  hhff_out_t push0,
    input  hhff_out_t push1,
    output logic      space,
    output logic      out_valid,
    input  logic      out_ready,
    output hhff_out_t out_data
);
    hhff_out_t  slot_reg [4];
    logic [1:0] rd_reg, rd_next;
    logic [1:0] wr_reg, wr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [2:0] added;

    assign out_valid = cnt_reg != 3'd0;
    assign out_data  = slot_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    // A byte may need two slots; allow it only when two are free after a pop.
    assign space     = (cnt_reg <= 3'd2) || (cnt_reg == 3'd3 && pop);
    assign added     = push ? {1'b0, push_count} : 3'd0;

    always_comb
    begin
        rd_next  = rd_reg + (pop ? 2'd1 : 2'd0);
        wr_next  = wr_reg + added[1:0];
        cnt_next = cnt_reg + added - (pop ? 3'd1 : 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && push_count != 2'd0)
            slot_reg[wr_reg] <= push0;
        if (push && push_count == 2'd2)
            slot_reg[wr_reg + 2'd1] <= push1;
    end
endmodule

/* sv/http_header_field_framer_core.sv */
// Top level of the header field framer: configuration registers, input
// register, byte scanner and output queue. Depends on hhff_pkg and submodules.
//
// Usage: header bytes arrive on the in channel, one transfer per byte, with
// last_byte set on the final byte of a header block. Each byte yields zero,
// one or two result transfers on the out channel: a finished field (kept or
// ignored with a cause) and, on the last byte, an accept or reject. The
// consumer drops the fields of a block that ends in reject.
// Timing: a byte is captured in the input register and scanned when the
// output queue has space; its results are registered in the queue and
// offered from there.
// Throughput: one byte per cycle, held back while the output queue lacks
// space. The four-entry output queue absorbs the two-result bytes.
// When the receiver stalls, the queue fills and in_ready drops; nothing is
// lost. Reset clears the parse state, the queue and the configuration
// (strict mode, both length limits 65534). Configuration is written through
// the cfg channel, which is always ready; writes beyond register 2 are ignored.
module http_header_field_framer_core
    import hhff_pkg::*;
#(
    parameter int MAX_HEADER_BYTES = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  hhff_in_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output hhff_out_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_value
);
    logic        relaxed_reg;
    logic [15:0] max_name_reg;
    logic [15:0] max_val_reg;
    hhff_in_t    item_reg;
    logic        item_valid_reg;
    logic        space;
    logic        step;
    logic [1:0]  res_count;
    hhff_out_t   res0;
    hhff_out_t   res1;

    assign cfg_ready = 1'b1;
    assign step      = item_valid_reg && space;
    assign in_ready  = !item_valid_reg || space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relaxed_reg  <= 1'b0;
            max_name_reg <= LEN_RESET;
            max_val_reg  <= LEN_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RELAXED:  relaxed_reg  <= cfg_value[0];
                CFG_MAX_NAME: max_name_reg <= cfg_value;
                CFG_MAX_VAL:  max_val_reg  <= cfg_value;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= in_data;
    end

    hhff_scan #(
        .POS_MAX (MAX_HEADER_BYTES - 1)
    ) u_scan (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (step),
        .item             (item_reg),
        .relaxed_mode     (relaxed_reg),
        .max_name_length  (max_name_reg),
        .max_value_length (max_val_reg),
        .res_count        (res_count),
        .res0             (res0),
        .res1             (res1)
    );

    hhff_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step),
        .push_count (res_count),
        .push0      (res0),
        .push1      (res1),
        .space      (space),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // Every byte that ends a block produces at least one result.
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        step && item_reg.last_byte |-> res_count != 2'd0)
        else $error("last byte produced no result");

    // A byte with a single result carries last_result on that result.
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_count == 2'd1 |-> res0.last_result)
        else $error("single result without last_result");

    // A terminating result is only produced for the last byte.
    a_term_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && res_count == 2'd2 |-> item_reg.last_byte)
        else $error("two results for a non-final byte");
endmodule
